FILE: design/dtq_pkg.sv
package dtq_pkg;

    localparam int TAG_W      = 8;
    localparam int DELAY_IN_W = 32;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_ADD  = 2'd1,
        KIND_DEL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_EXPIRED = 2'd0,
        ST_FULL    = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_NOP,
        OP_WALK,
        OP_REMOVE,
        OP_DEC
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic             commit;
        logic [TAG_W-1:0] tag;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic match;
        logic hit;
        logic expired;
    } cell_stat_t;

endpackage

FILE: design/dtq_in_if.sv
interface dtq_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic [dtq_pkg::TAG_W-1:0]        tag;
    logic [dtq_pkg::DELAY_IN_W-1:0]   delay;

    modport source (output valid, output kind, output tag, output delay, input ready);
    modport sink   (input valid, input kind, input tag, input delay, output ready);
endinterface

FILE: design/dtq_out_if.sv
interface dtq_out_if;
    logic                      valid;
    logic                      ready;
    logic [dtq_pkg::TAG_W-1:0] result_tag;
    logic [1:0]                status;
    logic                      last;

    modport source (output valid, output result_tag, output status, output last, input ready);
    modport sink   (input valid, input result_tag, input status, input last, output ready);
endinterface

FILE: design/dtq_cell.sv
module dtq_cell #(
    parameter int INDEX      = 0,
    parameter int DELAY_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtq_pkg::cell_ctl_t            ctl,
    input  logic [IDX_W-1:0]              pos,
    input  logic [DELAY_BITS-1:0]         tok_in,
    input  logic [dtq_pkg::TAG_W-1:0]     left_tag,
    input  logic [DELAY_BITS-1:0]         left_delta,
    input  logic                          left_valid,
    input  logic [dtq_pkg::TAG_W-1:0]     right_tag,
    input  logic [DELAY_BITS-1:0]         right_delta,
    input  logic                          right_valid,
    output logic [DELAY_BITS-1:0]         tok_out,
    output logic [dtq_pkg::TAG_W-1:0]     sh_tag,
    output logic                          sh_valid,
    output logic [DELAY_BITS-1:0]         fwd_delta,
    output logic [DELAY_BITS-1:0]         bwd_delta,
    output dtq_pkg::cell_stat_t           stat
);

    logic                          valid_reg, valid_next;
    logic [dtq_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [DELAY_BITS-1:0]         delta_reg, delta_next;
    logic [DELAY_BITS-1:0]         tok_reg, tok_next;
    logic                          here;
    logic                          after;

    assign here  = (pos == IDX_W'(INDEX));
    assign after = (pos < IDX_W'(INDEX));

    assign stat.valid   = valid_reg;
    assign stat.match   = valid_reg && (tag_reg == ctl.tag);
    assign stat.hit     = (ctl.op == dtq_pkg::OP_WALK) && here
                          && (!valid_reg || (tok_in < delta_reg));
    assign stat.expired = valid_reg && (delta_reg == '0);

    assign tok_out   = tok_reg;
    assign sh_tag    = tag_reg;
    assign sh_valid  = valid_reg;
    // the entry at the insertion point moves right carrying the reduced delta
    assign fwd_delta = here ? (delta_reg - tok_in) : delta_reg;
    assign bwd_delta = delta_reg;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        delta_next = delta_reg;
        tok_next   = tok_reg;
        unique case (ctl.op)
            dtq_pkg::OP_WALK:
            begin
                tok_next = tok_in - delta_reg;
                if (ctl.commit)
                begin
                    if (here)
                    begin
                        valid_next = 1'b1;
                        tag_next   = ctl.tag;
                        delta_next = tok_in;
                    end
                    else if (after)
                    begin
                        valid_next = left_valid;
                        tag_next   = left_tag;
                        delta_next = left_delta;
                    end
                end
            end
            dtq_pkg::OP_REMOVE:
            begin
                if (here || after)
                begin
                    valid_next = right_valid;
                    tag_next   = right_tag;
                    delta_next = here ? (right_delta + delta_reg) : right_delta;
                end
            end
            dtq_pkg::OP_DEC:
            begin
                if (here && (delta_reg != '0))
                begin
                    delta_next = delta_reg - DELAY_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        delta_reg <= delta_next;
        tok_reg   <= tok_next;
    end

endmodule

FILE: design/delta_timer_queue_core.sv
// Sequencing: an item is taken in one cycle and checked in the next; a tick then
// decrements the head and pops one expired timer per cycle while the result
// output is free, an add walks its remainder down the cell chain one cell per
// cycle, and a delete removes its entry in S_DEL. A new item is taken only in
// S_IDLE, once the last is through; a result stall holds a pop or an add reject.
// Reset: all cells empty, count zero, no clearing pass; ready right after reset.
module delta_timer_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DELAY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    dtq_in_if.sink      cmd,
    dtq_out_if.source   res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IN_W  = dtq_pkg::DELAY_IN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DEL,
        S_POP
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [dtq_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [DELAY_BITS-1:0]         d_reg, d_next;
    logic                          res_valid_reg, res_valid_next;
    logic [dtq_pkg::TAG_W-1:0]     res_tag_reg, res_tag_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic                          res_last_reg, res_last_next;

    logic [DELAY_BITS-1:0]         d_sat;
    dtq_pkg::cell_ctl_t            ctl;
    dtq_pkg::cell_stat_t           stat [DEPTH];
    logic [DEPTH-1:0]              match_vec;
    logic [DEPTH-1:0]              hit_vec;
    logic [DEPTH-1:0]              valid_vec;
    logic                          found;
    logic [IDX_W-1:0]              match_idx;
    logic                          out_free;
    logic                          full;

    logic [DELAY_BITS-1:0]         tok_chain [DEPTH];
    logic [dtq_pkg::TAG_W-1:0]     sh_tag    [DEPTH];
    logic                          sh_valid  [DEPTH];
    logic [DELAY_BITS-1:0]         fwd_delta [DEPTH];
    logic [DELAY_BITS-1:0]         bwd_delta [DEPTH];

    generate
        if (DELAY_BITS >= IN_W)
        begin : g_sat_wide
            assign d_sat = DELAY_BITS'(cmd.delay);
        end
        else
        begin : g_sat_narrow
            assign d_sat = (|cmd.delay[IN_W-1:DELAY_BITS]) ? '1
                                                           : cmd.delay[DELAY_BITS-1:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DELAY_BITS-1:0]     tok_src;
            logic [dtq_pkg::TAG_W-1:0] l_tag, r_tag;
            logic [DELAY_BITS-1:0]     l_delta, r_delta;
            logic                      l_valid, r_valid;

            if (gi == 0)
            begin : g_first
                assign tok_src = d_reg;
                assign l_tag   = '0;
                assign l_delta = '0;
                assign l_valid = 1'b0;
            end
            else
            begin : g_mid_l
                assign tok_src = tok_chain[gi-1];
                assign l_tag   = sh_tag[gi-1];
                assign l_delta = fwd_delta[gi-1];
                assign l_valid = sh_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_tag   = '0;
                assign r_delta = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_tag   = sh_tag[gi+1];
                assign r_delta = bwd_delta[gi+1];
                assign r_valid = sh_valid[gi+1];
            end

            dtq_cell #(
                .INDEX      (gi),
                .DELAY_BITS (DELAY_BITS),
                .IDX_W      (IDX_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .pos         (pos_reg),
                .tok_in      (tok_src),
                .left_tag    (l_tag),
                .left_delta  (l_delta),
                .left_valid  (l_valid),
                .right_tag   (r_tag),
                .right_delta (r_delta),
                .right_valid (r_valid),
                .tok_out     (tok_chain[gi]),
                .sh_tag      (sh_tag[gi]),
                .sh_valid    (sh_valid[gi]),
                .fwd_delta   (fwd_delta[gi]),
                .bwd_delta   (bwd_delta[gi]),
                .stat        (stat[gi])
            );

            assign match_vec[gi] = stat[gi].match;
            assign hit_vec[gi]   = stat[gi].hit;
            assign valid_vec[gi] = stat[gi].valid;
        end
    endgenerate

    // tags are unique in the queue, so an OR encoder is enough
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match_idx = match_idx | (match_vec[i] ? IDX_W'(i) : '0);
        end
    end

    assign found    = |match_vec;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign out_free = !res_valid_reg || res.ready;

    assign cmd.ready      = (state_reg == S_IDLE);
    assign res.valid      = res_valid_reg;
    assign res.result_tag = res_tag_reg;
    assign res.status     = res_status_reg;
    assign res.last       = res_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        tag_next        = tag_reg;
        d_next          = d_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        ctl.op          = dtq_pkg::OP_NOP;
        ctl.commit      = |hit_vec;
        ctl.tag         = tag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    tag_next   = cmd.tag;
                    d_next     = d_sat;
                    pos_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (kind_reg)
                    dtq_pkg::KIND_TICK:
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.op     = dtq_pkg::OP_DEC;
                            state_next = S_POP;
                        end
                    end
                    dtq_pkg::KIND_ADD:
                    begin
                        if ((d_reg == '0) || found || full)
                        begin
                            if (out_free)
                            begin
                                res_valid_next  = 1'b1;
                                res_tag_next    = tag_reg;
                                res_status_next = ((d_reg == '0) || found)
                                                  ? dtq_pkg::ST_REJECT
                                                  : dtq_pkg::ST_FULL;
                                res_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    dtq_pkg::KIND_DEL:
                    begin
                        if (found)
                        begin
                            pos_next   = match_idx;
                            state_next = S_DEL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                ctl.op = dtq_pkg::OP_WALK;
                if (ctl.commit)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            S_DEL:
            begin
                ctl.op     = dtq_pkg::OP_REMOVE;
                count_next = count_reg - CNT_W'(1);
                state_next = S_IDLE;
            end
            S_POP:
            begin
                if (stat[0].expired)
                begin
                    if (out_free)
                    begin
                        ctl.op          = dtq_pkg::OP_REMOVE;
                        count_next      = count_reg - CNT_W'(1);
                        res_valid_next  = 1'b1;
                        res_tag_next    = sh_tag[0];
                        res_status_next = dtq_pkg::ST_EXPIRED;
                        // new head is not decremented again, so it expires only at zero
                        res_last_next   = !stat[1].expired;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        tag_reg        <= tag_next;
        d_reg          <= d_next;
        res_tag_reg    <= res_tag_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("valid cells disagree with entry count");

    a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one insertion point");

    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("duplicate tag in queue");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && (pos_reg == IDX_W'(DEPTH - 1)) |-> ctl.commit)
        else $error("insert walk ran past the last cell");

endmodule
